// ===== rtl/core/brightest_pixel_tracker_top_defines.svh =====
// ----------------------------------------------------------------------------
// Brightest pixel tracker assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BRIGHTEST_PIXEL_TRACKER_TOP_DEFINES_SVH
`define BRIGHTEST_PIXEL_TRACKER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BPT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bpt_pkg.sv =====
// ----------------------------------------------------------------------------
// Brightest pixel tracker package
// Widths, color masks and the unpacked pixel type shared by the tracker.
// ----------------------------------------------------------------------------
package bpt_pkg;

  localparam int CHAN_BITS        = 8;
  localparam int LUMA_BITS        = 11;
  localparam int OUT_COORD_BITS   = 11;
  localparam int FRAME_WIDTH_BITS = 12;
  localparam int IN_DATA_BITS     = 16;
  localparam int OUT_DATA_BITS    = 64;

  localparam logic [CHAN_BITS-1:0]        RED_MASK          = 8'hF8;
  localparam logic [CHAN_BITS-1:0]        GREEN_LO_MASK     = 8'hE0;
  localparam logic [FRAME_WIDTH_BITS-1:0] FRAME_WIDTH_RESET = 12'd320;
  localparam logic [LUMA_BITS-1:0]        LUMA_MAX          = 11'd1752;

  typedef struct packed {
    logic [CHAN_BITS-1:0] red;
    logic [CHAN_BITS-1:0] green;
    logic [CHAN_BITS-1:0] blue;
    logic [LUMA_BITS-1:0] luma;
  } pixel_t;

endpackage

// ===== rtl/core/bpt_pixel_unpack.sv =====
// ----------------------------------------------------------------------------
// Brightest pixel tracker pixel unpack
// Expands an RGB565 word to left-aligned 8-bit channels and weighted luma.
// ----------------------------------------------------------------------------
module bpt_pixel_unpack (
  input  logic [bpt_pkg::IN_DATA_BITS-1:0] pixel_word,
  output bpt_pkg::pixel_t                  pixel
);

  logic [bpt_pkg::CHAN_BITS-1:0] hi_byte;
  logic [bpt_pkg::CHAN_BITS-1:0] lo_byte;
  logic [bpt_pkg::CHAN_BITS-1:0] red;
  logic [bpt_pkg::CHAN_BITS-1:0] green;
  logic [bpt_pkg::CHAN_BITS-1:0] blue;

  assign hi_byte = pixel_word[15:8];
  assign lo_byte = pixel_word[7:0];

  // Green straddles the two bus bytes: three bits from the high byte, three
  // from the top of the low byte.
  assign red   = hi_byte & bpt_pkg::RED_MASK;
  assign green = {hi_byte[2:0], 5'b00000} | ((lo_byte & bpt_pkg::GREEN_LO_MASK) >> 3);
  assign blue  = {lo_byte[4:0], 3'b000};

  assign pixel.red   = red;
  assign pixel.green = green;
  assign pixel.blue  = blue;
  assign pixel.luma  = {3'b000, red} + {1'b0, green, 2'b00} + {2'b00, blue, 1'b0};

endmodule

// ===== rtl/core/brightest_pixel_tracker_top.sv =====
// ----------------------------------------------------------------------------
// Brightest pixel tracker
// Finds the brightest RGB565 pixel of each frame and reports it once a frame.
// ----------------------------------------------------------------------------
// The tracker takes one RGB565 pixel per beat in raster order and accepts a
// new pixel every clock cycle; the only stall happens when a frame record is
// still waiting in the output register and the downstream side holds
// out_tready low, because the record register is the single place a result
// is held. Each pixel is expanded to 8-bit red, green and blue, weighted as
// r + 4g + 2b, and compared against the best luma of the current frame in the
// same cycle it is accepted. The first pixel reaching the highest luma wins.
// Column and row come from internal counters; the column wraps at frame_width
// (a width of zero acts as one) and the row saturates at its largest value.
// The beat carrying in_tlast closes the frame: its record appears on the
// output in the next cycle, and the best luma and both counters restart at
// zero. In an all-black frame the luma reads zero while color and position
// repeat the previous frame's winner. The user writes frame_width through
// cfg_wr_en / cfg_wr_data only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "brightest_pixel_tracker_top_defines.svh"

module brightest_pixel_tracker_top #(
  parameter int COORD_BITS = 11
) (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 cfg_wr_en,
  input  logic [bpt_pkg::FRAME_WIDTH_BITS-1:0] cfg_wr_data,   // frame_width

  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [bpt_pkg::IN_DATA_BITS-1:0]     in_tdata,      // [15:0] pixel_word
  input  logic                                 in_tlast,      // frame_end

  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [7:0] peak_red, [15:8] peak_green, [23:16] peak_blue, [34:24] peak_luma,
  // [45:35] peak_column, [56:46] peak_row, [63:57] zero
  output logic [bpt_pkg::OUT_DATA_BITS-1:0]    out_tdata
);

  // Counter compare width: must hold column + 1 and the full frame width.
  localparam int CMP_BITS = (COORD_BITS + 1 > bpt_pkg::FRAME_WIDTH_BITS) ?
                            COORD_BITS + 1 : bpt_pkg::FRAME_WIDTH_BITS;
  localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};
  localparam int PAD_BITS = bpt_pkg::OUT_DATA_BITS - 3 * bpt_pkg::CHAN_BITS
                            - bpt_pkg::LUMA_BITS - 2 * bpt_pkg::OUT_COORD_BITS;

  typedef struct packed {
    logic [bpt_pkg::CHAN_BITS-1:0]      red;
    logic [bpt_pkg::CHAN_BITS-1:0]      green;
    logic [bpt_pkg::CHAN_BITS-1:0]      blue;
    logic [bpt_pkg::LUMA_BITS-1:0]      luma;
    logic [bpt_pkg::OUT_COORD_BITS-1:0] column;
    logic [bpt_pkg::OUT_COORD_BITS-1:0] row;
  } peak_rec_t;

  logic [bpt_pkg::FRAME_WIDTH_BITS-1:0] frame_width_r;

  logic [bpt_pkg::LUMA_BITS-1:0] best_luma_r, best_luma_nxt;
  logic [bpt_pkg::CHAN_BITS-1:0] best_red_r, best_red_nxt;
  logic [bpt_pkg::CHAN_BITS-1:0] best_green_r, best_green_nxt;
  logic [bpt_pkg::CHAN_BITS-1:0] best_blue_r, best_blue_nxt;
  logic [COORD_BITS-1:0]         best_col_r, best_col_nxt;
  logic [COORD_BITS-1:0]         best_row_r, best_row_nxt;
  logic [COORD_BITS-1:0]         col_r, col_nxt;
  logic [COORD_BITS-1:0]         row_r, row_nxt;

  logic      out_valid_r, out_valid_nxt;
  peak_rec_t out_rec_r, out_rec_nxt;

  bpt_pkg::pixel_t     pixel;
  logic                in_accept;
  logic                beats_best;
  logic [CMP_BITS-1:0] col_inc;
  logic                col_wrap;

  bpt_pixel_unpack u_unpack (
    .pixel_word (in_tdata),
    .pixel      (pixel)
  );

  // A new pixel may enter whenever the record register is empty or draining.
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  assign beats_best = pixel.luma > best_luma_r;
  assign col_inc    = CMP_BITS'(col_r) + CMP_BITS'(1);
  assign col_wrap   = (col_inc >= CMP_BITS'(frame_width_r)) || (col_r == COORD_MAX);

  always_comb begin
    best_luma_nxt  = best_luma_r;
    best_red_nxt   = best_red_r;
    best_green_nxt = best_green_r;
    best_blue_nxt  = best_blue_r;
    best_col_nxt   = best_col_r;
    best_row_nxt   = best_row_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_rec_nxt    = out_rec_r;

    if (in_accept) begin
      if (beats_best) begin
        best_luma_nxt  = pixel.luma;
        best_red_nxt   = pixel.red;
        best_green_nxt = pixel.green;
        best_blue_nxt  = pixel.blue;
        best_col_nxt   = col_r;
        best_row_nxt   = row_r;
      end

      if (in_tlast) begin
        // The closing pixel is already folded into the running best above.
        out_valid_nxt      = 1'b1;
        out_rec_nxt.red    = best_red_nxt;
        out_rec_nxt.green  = best_green_nxt;
        out_rec_nxt.blue   = best_blue_nxt;
        out_rec_nxt.luma   = best_luma_nxt;
        out_rec_nxt.column = bpt_pkg::OUT_COORD_BITS'(best_col_nxt);
        out_rec_nxt.row    = bpt_pkg::OUT_COORD_BITS'(best_row_nxt);
        best_luma_nxt      = '0;
        col_nxt            = '0;
        row_nxt            = '0;
      end else if (col_wrap) begin
        col_nxt = '0;
        if (row_r != COORD_MAX) begin
          row_nxt = row_r + COORD_BITS'(1);
        end
      end else begin
        col_nxt = col_inc[COORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r <= bpt_pkg::FRAME_WIDTH_RESET;
      best_luma_r   <= '0;
      best_red_r    <= '0;
      best_green_r  <= '0;
      best_blue_r   <= '0;
      best_col_r    <= '0;
      best_row_r    <= '0;
      col_r         <= '0;
      row_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        frame_width_r <= cfg_wr_data;
      end
      best_luma_r  <= best_luma_nxt;
      best_red_r   <= best_red_nxt;
      best_green_r <= best_green_nxt;
      best_blue_r  <= best_blue_nxt;
      best_col_r   <= best_col_nxt;
      best_row_r   <= best_row_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // The record payload needs no reset; it is qualified by out_valid_r.
  always_ff @(posedge clk) begin
    out_rec_r <= out_rec_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_BITS{1'b0}}, out_rec_r.row, out_rec_r.column,
                       out_rec_r.luma, out_rec_r.blue, out_rec_r.green, out_rec_r.red};

  // A closing beat always produces a record and restarts the frame state.
  `BPT_ASSERT_NEXT(a_last_gives_record, in_accept && in_tlast, out_valid_r, "frame end lost")
  `BPT_ASSERT_NEXT(a_last_clears_frame, in_accept && in_tlast,
                   best_luma_r == '0 && col_r == '0 && row_r == '0, "frame state not cleared")
  // The row advances by at most one line per pixel.
  `BPT_ASSERT_NEXT(a_row_step, in_accept && !in_tlast,
                   row_r == $past(row_r) || row_r == $past(row_r) + 1, "row jumped")
  // Nothing is accepted over a full record register that is not draining.
  `BPT_ASSERT_SAME(a_no_overrun, out_valid_r && !out_tready, !in_accept, "record overrun")
  `BPT_ASSERT_SAME(a_luma_range, out_valid_r, out_rec_r.luma <= bpt_pkg::LUMA_MAX,
                   "luma out of range")

endmodule

// ===== tb/brightest_pixel_tracker_top_test.sv =====
// ----------------------------------------------------------------------------
// Brightest pixel tracker testbench
// Streams RGB565 frames into the tracker and checks every frame record
// against a cycle-free software tracker kept inside this module.
// ----------------------------------------------------------------------------
// Pixels are driven on the falling edge and every handshake is sampled on the
// rising edge. Each accepted pixel beat updates the local tracker state; a
// beat with in_tlast queues the record that the block must emit. A checker
// process pops that queue on every accepted output beat and compares the six
// record fields one by one. The run covers directed corner cases (black
// frames, color extremes, ties, narrow lines, long frames with wide lines)
// and then random frames under three idling profiles.
// ----------------------------------------------------------------------------
module brightest_pixel_tracker_top_test;

  localparam int COORD_BITS = 11;
  localparam logic [COORD_BITS-1:0] COORD_MAX = '1;
  // Watchdog bound, set well above the length of the slowest correct run.
  localparam int CYCLE_LIMIT = 400000;
  // A frame record shows up in the cycle after its last pixel, so these quiet
  // cycles are plenty before touching the register or ending the run.
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTED = 10;

  // Same bit order as the record on out_tdata: red in the lowest byte.
  typedef struct packed {
    logic [bpt_pkg::OUT_COORD_BITS-1:0] row;
    logic [bpt_pkg::OUT_COORD_BITS-1:0] column;
    logic [bpt_pkg::LUMA_BITS-1:0]      luma;
    logic [bpt_pkg::CHAN_BITS-1:0]      blue;
    logic [bpt_pkg::CHAN_BITS-1:0]      green;
    logic [bpt_pkg::CHAN_BITS-1:0]      red;
  } peak_record_t;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 cfg_wr_en = 1'b0;
  logic [bpt_pkg::FRAME_WIDTH_BITS-1:0] cfg_wr_data = '0;
  logic                                 in_tvalid = 1'b0;
  logic                                 in_tready;
  logic [bpt_pkg::IN_DATA_BITS-1:0]     in_tdata = '0;   // [15:0] pixel_word
  logic                                 in_tlast = 1'b0; // frame_end
  logic                                 out_tvalid;
  logic                                 out_tready = 1'b1;
  // [7:0] peak_red, [15:8] peak_green, [23:16] peak_blue, [34:24] peak_luma,
  // [45:35] peak_column, [56:46] peak_row, [63:57] zero
  logic [bpt_pkg::OUT_DATA_BITS-1:0]    out_tdata;

  // Local copy of the tracker state. best_peak holds the winner so far; its
  // luma is cleared at each frame end while color and position are kept.
  logic [bpt_pkg::FRAME_WIDTH_BITS-1:0] line_width = bpt_pkg::FRAME_WIDTH_RESET;
  peak_record_t                         best_peak = '0;
  logic [COORD_BITS-1:0]                column_count = '0;
  logic [COORD_BITS-1:0]                row_count = '0;

  peak_record_t pending_peaks[$];
  int           mismatch_count = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;

  brightest_pixel_tracker_top #(
    .COORD_BITS(COORD_BITS)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // The receiver decides on each falling edge whether to take the next beat.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Expand one accepted pixel, fold it into the running maximum and advance
  // the raster counters; the last pixel of a frame queues the frame record.
  function automatic void track_pixel(input logic [bpt_pkg::IN_DATA_BITS-1:0] word,
                                      input logic frame_end);
    logic [bpt_pkg::CHAN_BITS-1:0] red;
    logic [bpt_pkg::CHAN_BITS-1:0] green;
    logic [bpt_pkg::CHAN_BITS-1:0] blue;
    logic [bpt_pkg::LUMA_BITS-1:0] luma;
    logic [COORD_BITS:0]           next_column;
    red   = {word[15:11], 3'b000};
    green = {word[10:5], 2'b00};
    blue  = {word[4:0], 3'b000};
    luma  = bpt_pkg::LUMA_BITS'(red) + (bpt_pkg::LUMA_BITS'(green) << 2)
            + (bpt_pkg::LUMA_BITS'(blue) << 1);
    // Strictly greater, so the first pixel reaching the maximum keeps it.
    if (luma > best_peak.luma) begin
      best_peak = '{row: row_count, column: column_count, luma: luma,
                    blue: blue, green: green, red: red};
    end
    if (frame_end) begin
      pending_peaks.push_back(best_peak);
      best_peak.luma = '0;
      column_count = '0;
      row_count = '0;
    end else begin
      // A width of zero wraps on every pixel, just like a width of one, and
      // the column counter also wraps at its own largest value.
      next_column = column_count + 1'b1;
      if (next_column >= line_width || column_count == COORD_MAX) begin
        column_count = '0;
        if (row_count != COORD_MAX) row_count = row_count + 1'b1;
      end else begin
        column_count = next_column[COORD_BITS-1:0];
      end
    end
  endfunction

  // Offer one pixel beat, possibly after some idle cycles, and hold it until
  // the tracker takes it. Returns on the falling edge after the handshake.
  task automatic send_pixel(input logic [bpt_pkg::IN_DATA_BITS-1:0] word,
                            input logic frame_end);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tlast  <= frame_end;
    do @(posedge clk); while (!in_tready);
    track_pixel(word, frame_end);
    @(negedge clk);
  endtask

  // Stop sending and wait until every queued frame record has been seen.
  task automatic wait_for_records();
    in_tvalid <= 1'b0;
    while (pending_peaks.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // The register is only written while the tracker is idle between frames.
  task automatic write_frame_width(input logic [bpt_pkg::FRAME_WIDTH_BITS-1:0] width);
    wait_for_records();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= width;
    @(negedge clk);
    cfg_wr_en  <= 1'b0;
    line_width = width;
  endtask

  task automatic flag_mismatch(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTED) begin
      $display("Mismatch on %s: expected 0x%0h, got 0x%0h", field, want, got);
    end
  endtask

  // Every accepted output beat must match the oldest queued frame record.
  always @(posedge clk) begin : check_records
    peak_record_t seen;
    peak_record_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen = out_tdata[$bits(peak_record_t)-1:0];
      if (pending_peaks.size() == 0) begin
        flag_mismatch("record beat with no frame closed", '0, out_tdata);
      end else begin
        want = pending_peaks.pop_front();
        if (seen.red != want.red) flag_mismatch("peak_red", want.red, seen.red);
        if (seen.green != want.green) flag_mismatch("peak_green", want.green, seen.green);
        if (seen.blue != want.blue) flag_mismatch("peak_blue", want.blue, seen.blue);
        if (seen.luma != want.luma) flag_mismatch("peak_luma", want.luma, seen.luma);
        if (seen.column != want.column) begin
          flag_mismatch("peak_column", want.column, seen.column);
        end
        if (seen.row != want.row) flag_mismatch("peak_row", want.row, seen.row);
      end
    end
  end

  // A black frame straight after reset reports zero luma, color and position.
  task automatic test_black_after_reset();
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'h0000, 1'b1);
  endtask

  // Single-pixel frame, each channel at full scale on its own, the brightest
  // code, a later tie that must lose, a winning last pixel, and a black frame
  // that keeps the previous winner's color and position.
  task automatic test_color_extremes();
    send_pixel(16'h0821, 1'b1);
    send_pixel(16'h001F, 1'b0);
    send_pixel(16'h07E0, 1'b0);
    send_pixel(16'hF800, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0001, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0020, 1'b1);
    send_pixel(16'h0841, 1'b0);
    send_pixel(16'hF81F, 1'b1);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'h0000, 1'b1);
  endtask

  // Widths one and zero put every pixel on a new line; width two alternates.
  task automatic test_narrow_lines();
    write_frame_width(12'd1);
    for (int i = 0; i < 4; i++) send_pixel((i == 2) ? 16'hF7BE : 16'h1082, i == 3);
    write_frame_width(12'd0);
    for (int i = 0; i < 4; i++) send_pixel((i == 1) ? 16'hF7BE : 16'h1082, i == 3);
    write_frame_width(12'd2);
    for (int i = 0; i < 5; i++) send_pixel((i == 3) ? 16'hFFFF : 16'h1082, i == 4);
  endtask

  // Long frames: two with lines wider than the frame and one where every
  // pixel starts a new line. Filler pixels can never reach full luma.
  task automatic test_counter_limits();
    int lengths[3];
    int peak_at[3];
    logic [bpt_pkg::FRAME_WIDTH_BITS-1:0] widths[3];
    widths  = '{12'd4095, 12'd2048, 12'd0};
    lengths = '{200, 200, 200};
    peak_at = '{120, 199, 37};
    for (int f = 0; f < 3; f++) begin
      write_frame_width(widths[f]);
      for (int i = 0; i < lengths[f]; i++) begin
        send_pixel((i == peak_at[f]) ? 16'hFFFF : (16'($urandom) & 16'h7BEF),
                   i == lengths[f] - 1);
      end
    end
  endtask

  function automatic logic [bpt_pkg::FRAME_WIDTH_BITS-1:0] pick_width();
    case ($urandom_range(7))
      0:       return 12'd0;
      1:       return 12'd1;
      2:       return 12'd4095;
      3:       return 12'd2048;
      4:       return bpt_pkg::FRAME_WIDTH_BITS'($urandom);
      default: return bpt_pkg::FRAME_WIDTH_BITS'($urandom_range(2, 16));
    endcase
  endfunction

  // Mostly random colors, with black pixels, full-scale pixels and repeats
  // of the previous pixel mixed in so that ties show up often.
  function automatic logic [bpt_pkg::IN_DATA_BITS-1:0] random_pixel(
    input logic [bpt_pkg::IN_DATA_BITS-1:0] prev);
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return prev;
      default: return bpt_pkg::IN_DATA_BITS'($urandom);
    endcase
  endfunction

  // Random frames, mostly short so that records come often. Between frames
  // the width is sometimes rewritten or the sender waits for all records.
  task automatic test_random_frames(input int item_target);
    int                               sent;
    int                               frame_len;
    bit                               black;
    logic [bpt_pkg::IN_DATA_BITS-1:0] word;
    logic [bpt_pkg::IN_DATA_BITS-1:0] prev;
    sent = 0;
    prev = '0;
    while (sent < item_target) begin
      case ($urandom_range(15))
        0:       write_frame_width(pick_width());
        1:       wait_for_records();
        default: ;
      endcase
      frame_len = ($urandom_range(7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
      black = ($urandom_range(9) == 0);
      for (int i = 0; i < frame_len; i++) begin
        word = black ? 16'h0000 : random_pixel(prev);
        send_pixel(word, i == frame_len - 1);
        prev = word;
      end
      sent += frame_len;
    end
  endtask

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    // First profile: the sender rarely idles while the receiver stalls often.
    send_idle_pct  = 7;
    recv_stall_pct = 54;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    test_black_after_reset();
    test_color_extremes();
    test_narrow_lines();
    test_random_frames(280);
    // Second profile: the sender idles often, the receiver rarely stalls.
    send_idle_pct  = 54;
    recv_stall_pct = 7;
    test_counter_limits();
    test_random_frames(230);
    // Last profile: back-to-back beats on both sides.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_frames(230);
    wait_for_records();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
